// ----- rtl/ssii_pkg.sv -----
package ssii_pkg;

    // Field widths
    localparam int VAL_W  = 32;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 3;

    // Default capacity of each set
    localparam int SET_DEPTH_DEF = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INS_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ISECT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_COMMON    = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

    // Operation broadcast to every cell of a chain
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CMP,
        OP_INS,
        OP_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                op;
        logic signed [VAL_W-1:0] key;
    } t_cell_ctrl;

endpackage

// ----- rtl/ssii_cell.sv -----
module ssii_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssii_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_occ,
    input  logic                               i_tail,
    input  logic                               i_prev_lt,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_prev_value,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_next_value,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_head_value,
    output logic signed [ssii_pkg::VAL_W-1:0]  o_value,
    output logic                               o_lt,
    output logic                               o_eq
);

    logic signed [ssii_pkg::VAL_W-1:0] r_value;
    logic                              r_lt;
    logic                              r_eq;

    // Compare the stored entry against the key; empty entries never match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctrl.op == ssii_pkg::OP_CMP) begin
            r_lt <= i_occ && (r_value < i_ctrl.key);
            r_eq <= i_occ && (r_value == i_ctrl.key);
        end
    end

    // Keep, take the key, shift up from below, or rotate down toward the head
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            ssii_pkg::OP_INS: begin
                if (!r_lt) begin
                    r_value <= i_prev_lt ? i_ctrl.key : i_prev_value;
                end
            end
            ssii_pkg::OP_ROT: begin
                r_value <= i_tail ? i_head_value : i_next_value;
            end
            ssii_pkg::OP_HOLD, ssii_pkg::OP_CMP: begin
                r_value <= r_value;
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

// ----- rtl/ssii_chain.sv -----
module ssii_chain #(
    parameter int DEPTH = ssii_pkg::SET_DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ssii_pkg::t_cell_ctrl               i_ctrl,
    input  logic [CNT_W-1:0]                   i_count,
    output logic signed [ssii_pkg::VAL_W-1:0]  o_head,
    output logic                               o_dup
);

    logic [DEPTH-1:0]                  lt;
    logic [DEPTH-1:0]                  eq;
    logic signed [ssii_pkg::VAL_W-1:0] val [DEPTH];

    // Build the row of cells; each sees its lower and upper neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                              prev_lt;
        logic signed [ssii_pkg::VAL_W-1:0] prev_val;
        logic signed [ssii_pkg::VAL_W-1:0] next_val;
        logic                              occ;
        logic                              tail;

        if (g == 0) begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_val = i_ctrl.key;
        end else begin : g_inner
            assign prev_lt  = lt[g-1];
            assign prev_val = val[g-1];
        end

        if (g == DEPTH - 1) begin : g_top
            assign next_val = val[0];
        end else begin : g_below
            assign next_val = val[g+1];
        end

        assign occ  = CNT_W'(g) < i_count;
        assign tail = CNT_W'(g + 1) == i_count;

        ssii_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (i_ctrl),
            .i_occ        (occ),
            .i_tail       (tail),
            .i_prev_lt    (prev_lt),
            .i_prev_value (prev_val),
            .i_next_value (next_val),
            .i_head_value (val[0]),
            .o_value      (val[g]),
            .o_lt         (lt[g]),
            .o_eq         (eq[g])
        );
    end

    assign o_head = val[0];
    assign o_dup  = |eq;

endmodule

// ----- rtl/sorted_set_insert_intersect_top.sv -----
// Insert and clear: accepted in idle, result registered from the insert or reply state
//   (insert compares in all cells, then shifts); the input stalls until it is placed.
// Intersect: a merge walk, one head compare per cycle over the rotating cell chains
//   while no match waits on a stalled output, then a flush, then the chains rotate
//   back to order. One command is in flight; output stalls hold the walk.
// Reset (synchronous, active low) empties both sets and drops any pending result.
module sorted_set_insert_intersect_top #(
    parameter int SET_DEPTH = ssii_pkg::SET_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ssii_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [ssii_pkg::VAL_W-1:0]  o_out_value,
    output logic [ssii_pkg::STAT_W-1:0]        o_status,
    output logic                               o_last
);

    localparam int CNT_W = $clog2(SET_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_REPLY,
        S_MERGE,
        S_FLUSH,
        S_RESTORE
    } t_state;

    t_state                            r_state, n_state;
    logic [ssii_pkg::CMD_W-1:0]        r_cmd, n_cmd;
    logic signed [ssii_pkg::VAL_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]                  r_cnt_a, n_cnt_a;
    logic [CNT_W-1:0]                  r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]                  r_i, n_i;
    logic [CNT_W-1:0]                  r_j, n_j;
    logic                              r_pend_valid, n_pend_valid;
    logic signed [ssii_pkg::VAL_W-1:0] r_pend_value, n_pend_value;
    logic [ssii_pkg::STAT_W-1:0]       r_rep_status, n_rep_status;
    logic                              r_out_valid;
    logic signed [ssii_pkg::VAL_W-1:0] r_out_value;
    logic [ssii_pkg::STAT_W-1:0]       r_out_status;
    logic                              r_out_last;

    ssii_pkg::t_cell_ctrl              ctrl_a, ctrl_b;
    logic signed [ssii_pkg::VAL_W-1:0] head_a, head_b;
    logic                              dup_a, dup_b;
    logic                              out_free;
    logic                              emit;
    logic signed [ssii_pkg::VAL_W-1:0] emit_value;
    logic [ssii_pkg::STAT_W-1:0]       emit_status;
    logic                              emit_last;
    logic                              sel_b;
    logic                              ins_dup;
    logic                              ins_full;

    ssii_chain #(.DEPTH(SET_DEPTH)) u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl_a),
        .i_count (r_cnt_a),
        .o_head  (head_a),
        .o_dup   (dup_a)
    );

    ssii_chain #(.DEPTH(SET_DEPTH)) u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl_b),
        .i_count (r_cnt_b),
        .o_head  (head_b),
        .o_dup   (dup_b)
    );

    assign out_free = !r_out_valid || !i_out_stall;
    assign sel_b    = r_cmd == ssii_pkg::CMD_INS_B;
    assign ins_dup  = sel_b ? dup_b : dup_a;
    assign ins_full = sel_b ? (r_cnt_b == CNT_W'(SET_DEPTH)) : (r_cnt_a == CNT_W'(SET_DEPTH));

    // Sequence one command: drive the chains and pick the next transaction to emit
    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_i          = r_i;
        n_j          = r_j;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_rep_status = r_rep_status;
        ctrl_a       = '{op: ssii_pkg::OP_HOLD, key: r_key};
        ctrl_b       = '{op: ssii_pkg::OP_HOLD, key: r_key};
        emit         = 1'b0;
        emit_value   = '0;
        emit_status  = ssii_pkg::ST_EMPTY;
        emit_last    = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = i_command;
                    n_key = i_value;
                    unique case (i_command)
                        ssii_pkg::CMD_INS_A: begin
                            ctrl_a  = '{op: ssii_pkg::OP_CMP, key: i_value};
                            n_state = S_INS;
                        end
                        ssii_pkg::CMD_INS_B: begin
                            ctrl_b  = '{op: ssii_pkg::OP_CMP, key: i_value};
                            n_state = S_INS;
                        end
                        ssii_pkg::CMD_ISECT: begin
                            n_i          = '0;
                            n_j          = '0;
                            n_pend_valid = 1'b0;
                            n_state      = S_MERGE;
                        end
                        ssii_pkg::CMD_CLEAR: begin
                            n_cnt_a      = '0;
                            n_cnt_b      = '0;
                            n_rep_status = ssii_pkg::ST_CLEARED;
                            n_state      = S_REPLY;
                        end
                    endcase
                end
            end
            S_INS: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_value = r_key;
                    n_state    = S_IDLE;
                    priority if (ins_dup) begin
                        emit_status = ssii_pkg::ST_DUPLICATE;
                    end else if (ins_full) begin
                        emit_status = ssii_pkg::ST_FULL;
                    end else begin
                        emit_status = ssii_pkg::ST_INSERTED;
                        if (sel_b) begin
                            ctrl_b  = '{op: ssii_pkg::OP_INS, key: r_key};
                            n_cnt_b = r_cnt_b + CNT_W'(1);
                        end else begin
                            ctrl_a  = '{op: ssii_pkg::OP_INS, key: r_key};
                            n_cnt_a = r_cnt_a + CNT_W'(1);
                        end
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit        = 1'b1;
                    emit_status = r_rep_status;
                    n_state     = S_IDLE;
                end
            end
            S_MERGE: begin
                if (r_i < r_cnt_a && r_j < r_cnt_b) begin
                    priority if (head_a < head_b) begin
                        ctrl_a.op = ssii_pkg::OP_ROT;
                        n_i       = r_i + CNT_W'(1);
                    end else if (head_a > head_b) begin
                        ctrl_b.op = ssii_pkg::OP_ROT;
                        n_j       = r_j + CNT_W'(1);
                    end else if (!r_pend_valid || out_free) begin
                        // Push the previous common element out; hold this one back
                        emit         = r_pend_valid;
                        emit_value   = r_pend_value;
                        emit_status  = ssii_pkg::ST_COMMON;
                        emit_last    = 1'b0;
                        n_pend_valid = 1'b1;
                        n_pend_value = head_a;
                        ctrl_a.op    = ssii_pkg::OP_ROT;
                        ctrl_b.op    = ssii_pkg::OP_ROT;
                        n_i          = r_i + CNT_W'(1);
                        n_j          = r_j + CNT_W'(1);
                    end
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_value   = r_pend_valid ? r_pend_value : '0;
                    emit_status  = r_pend_valid ? ssii_pkg::ST_COMMON : ssii_pkg::ST_EMPTY;
                    n_pend_valid = 1'b0;
                    n_state      = S_RESTORE;
                end
            end
            S_RESTORE: begin
                // Rotate each chain until it has turned through all its entries
                if (r_i < r_cnt_a) begin
                    ctrl_a.op = ssii_pkg::OP_ROT;
                    n_i       = r_i + CNT_W'(1);
                end
                if (r_j < r_cnt_b) begin
                    ctrl_b.op = ssii_pkg::OP_ROT;
                    n_j       = r_j + CNT_W'(1);
                end
                if (r_i == r_cnt_a && r_j == r_cnt_b) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, set counts and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt_a      <= n_cnt_a;
            r_cnt_b      <= n_cnt_b;
            r_i          <= n_i;
            r_j          <= n_j;
            r_pend_valid <= n_pend_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_pend_value <= n_pend_value;
        r_rep_status <= n_rep_status;
        if (emit) begin
            r_out_value  <= emit_value;
            r_out_status <= emit_status;
            r_out_last   <= emit_last;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_status    = r_out_status;
    assign o_last      = r_out_last;

    // Set counts stay within capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= CNT_W'(SET_DEPTH) && r_cnt_b <= CNT_W'(SET_DEPTH))
        else $error("set count exceeds capacity");

    // Merge and restore pointers never pass the counts
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE || r_state == S_RESTORE) |-> (r_i <= r_cnt_a && r_j <= r_cnt_b))
        else $error("merge pointer beyond set count");

    // A held-back common element exists only during an intersect walk
    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_MERGE || r_state == S_FLUSH))
        else $error("pending element outside intersect");

    // Flush always places the closing transaction of an intersect
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && out_free) |=> (r_out_valid && r_out_last))
        else $error("intersect closed without last marker");

endmodule

// ----- tb/sv/ssii_checker.sv -----
module ssii_checker #(
    parameter int SET_DEPTH = ssii_pkg::SET_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic [ssii_pkg::CMD_W-1:0]         i_command,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_value,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic signed [ssii_pkg::VAL_W-1:0]  i_out_value,
    input  logic [ssii_pkg::STAT_W-1:0]        i_status,
    input  logic                               i_last,
    output int                                 o_errors,
    output int                                 o_pending
);
    import ssii_pkg::*;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [STAT_W-1:0]       status;
        logic                    last;
    } t_set_result;

    // Shadow copy of both sorted sets, index 0 is set A, index 1 is set B
    logic signed [VAL_W-1:0] set_vals [2][SET_DEPTH];
    int                      set_count [2];

    t_set_result expected_results [$];
    int          mismatch_count = 0;

    assign o_errors = mismatch_count;

    // Search first, so a duplicate into a full set still reports duplicate
    function automatic logic [STAT_W-1:0] place_value(input int s,
                                                      input logic signed [VAL_W-1:0] v);
        int pos;
        int n;
        pos = 0;
        n = set_count[s];
        while (pos < n && set_vals[s][pos] < v) pos++;
        if (pos < n && set_vals[s][pos] == v) return ST_DUPLICATE;
        if (n >= SET_DEPTH) return ST_FULL;
        for (int i = n; i > pos; i--) set_vals[s][i] = set_vals[s][i-1];
        set_vals[s][pos] = v;
        set_count[s] = n + 1;
        return ST_INSERTED;
    endfunction

    // Merge-walk both sets and queue every common value in ascending order
    function automatic void predict_intersection();
        logic signed [VAL_W-1:0] common_vals [$];
        int i;
        int j;
        t_set_result res;
        i = 0;
        j = 0;
        while (i < set_count[0] && j < set_count[1]) begin
            if (set_vals[0][i] < set_vals[1][j]) begin
                i++;
            end else if (set_vals[0][i] > set_vals[1][j]) begin
                j++;
            end else begin
                common_vals.push_back(set_vals[0][i]);
                i++;
                j++;
            end
        end
        if (common_vals.size() == 0) begin
            res = '{value: '0, status: ST_EMPTY, last: 1'b1};
            expected_results.push_back(res);
        end else begin
            foreach (common_vals[k]) begin
                res = '{value: common_vals[k], status: ST_COMMON,
                        last: (k == common_vals.size() - 1)};
                expected_results.push_back(res);
            end
        end
    endfunction

    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic signed [VAL_W-1:0] v);
        t_set_result res;
        case (cmd)
            CMD_INS_A: begin
                res = '{value: v, status: place_value(0, v), last: 1'b1};
                expected_results.push_back(res);
            end
            CMD_INS_B: begin
                res = '{value: v, status: place_value(1, v), last: 1'b1};
                expected_results.push_back(res);
            end
            CMD_ISECT: begin
                predict_intersection();
            end
            default: begin
                set_count[0] = 0;
                set_count[1] = 0;
                res = '{value: '0, status: ST_CLEARED, last: 1'b1};
                expected_results.push_back(res);
            end
        endcase
    endfunction

    // Compare each output transaction, then predict from each input transaction
    always @(posedge i_clk) begin
        t_set_result exp_res;
        if (!i_rst_n) begin
            expected_results.delete();
            set_count[0] = 0;
            set_count[1] = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result value=%0d status=%0d last=%0b",
                             $time, i_out_value, i_status, i_last);
                    mismatch_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_out_value !== exp_res.value) begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, exp_res.value, i_out_value);
                        mismatch_count++;
                    end
                    if (i_status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, i_status);
                        mismatch_count++;
                    end
                    if (i_last !== exp_res.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_res.last, i_last);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) predict_command(i_command, i_value);
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- tb/sv/sorted_set_insert_intersect_top_tb.sv -----
module sorted_set_insert_intersect_top_tb;
    import ssii_pkg::*;

    localparam int DEPTH      = SET_DEPTH_DEF;
    localparam int NUM_RANDOM = 200;
    localparam int DRAIN_CYC  = 100;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        command = CMD_INS_A;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [VAL_W-1:0] out_value;
    logic [STAT_W-1:0]       status;
    logic                    last;
    logic                    calm = 1'b0;
    int                      errors;
    int                      pending;

    always #5 i_clk = ~i_clk;

    sorted_set_insert_intersect_top #(
        .SET_DEPTH(DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_command  (command),
        .i_value    (value),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_value(out_value),
        .o_status   (status),
        .o_last     (last)
    );

    ssii_checker #(
        .SET_DEPTH(DEPTH)
    ) checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_stall (in_stall),
        .i_command  (command),
        .i_value    (value),
        .i_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_out_value(out_value),
        .i_status   (status),
        .i_last     (last),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Stall the result channel at random, except in the calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < 19);
        end
    end

    // Insert values cluster in a narrow window so the sets overlap often
    function automatic logic signed [VAL_W-1:0] pick_value();
        int unsigned r;
        int          k;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            k = $urandom_range(0, 23);
            return k - 12;
        end
        if (r < 70) begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh8000_0001;
                2: return 32'sh7FFF_FFFF;
                default: return 32'sh7FFF_FFFE;
            endcase
        end
        return $urandom();
    endfunction

    // Drive one input transaction, with an optional random gap in front
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic signed [VAL_W-1:0] val);
        while (!calm && $urandom_range(0, 99) < 19) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        logic signed [VAL_W-1:0] fill_vals [DEPTH];
        int unsigned             r;

        fill_vals = '{32'sh7FFF_FFFF, 1000, 7, 1, 0, -1, -3, -50, -1000,
                      32'sh8000_0000, 300, 20, -20, 99, -99, 55};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty intersection, clear, fill A, full and duplicate-into-full
        send_command(CMD_ISECT, 32'sh1234_5678);
        send_command(CMD_CLEAR, -1);
        foreach (fill_vals[k]) send_command(CMD_INS_A, fill_vals[k]);
        send_command(CMD_INS_A, 12345);
        send_command(CMD_INS_A, 0);
        send_command(CMD_INS_B, 32'sh8000_0000);
        send_command(CMD_INS_B, 32'sh7FFF_FFFF);
        send_command(CMD_INS_B, 32'sh7FFF_FFFF);
        send_command(CMD_ISECT, 0);
        send_command(CMD_CLEAR, 32'sh5555_AAAA);

        // Random: mostly inserts, with random intersects and rare clears
        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == NUM_RANDOM / 2) wait_drained();
            calm <= (n >= 120 && n < 160);
            r = $urandom_range(0, 99);
            if (r < 42) begin
                send_command(CMD_INS_A, pick_value());
            end else if (r < 84) begin
                send_command(CMD_INS_B, pick_value());
            end else if (r < 97) begin
                send_command(CMD_ISECT, $urandom());
            end else begin
                send_command(CMD_CLEAR, $urandom());
            end
        end

        // Drain, then allow for any stray trailing result
        calm <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Bound the run in case the block hangs
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ssii_pkg.sv
rtl/ssii_cell.sv
rtl/ssii_chain.sv
rtl/sorted_set_insert_intersect_top.sv
tb/sv/ssii_checker.sv
tb/sv/sorted_set_insert_intersect_top_tb.sv
